// ----- rtl/pns_pkg.sv -----
// ---------------------------------------------------------------------------
// pns_pkg: shared types and constants for pad noise subtraction
// Field widths, register indexes, status codes and the sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

  localparam int LANES     = 8;      // samples per request
  localparam int RAW_W     = 12;     // raw ADC sample width
  localparam int OUT_W     = 18;     // corrected sample, signed Q14.4
  localparam int REF_W     = 18;     // stored reference sample, signed Q14.4
  localparam int BL_W      = 16;     // baseline, unsigned Q12.4
  localparam int AMP_W     = 16;     // amplitude, signed Q4.12
  localparam int AMP_FRAC  = 12;     // fraction bits of the amplitude
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 10;
  localparam int WS_W      = 9;      // window start width
  localparam int WE_W      = 10;     // window end width
  localparam int ADC_MAX   = 4095;
  localparam int PRD_W     = 2 * REF_W;

  localparam logic [AMP_W-1:0] AMP_UNITY = 16'd4096;
  localparam logic [WE_W-1:0]  WEND_RST  = 10'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WSTART = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEND   = 2'd2;

  // op codes of an input request
  localparam logic OP_REF = 1'b0;
  localparam logic OP_PAD = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_REF   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BL_SWEEP,
    S_BL_DIV,
    S_ST_SWEEP,
    S_AMP_DIV,
    S_OUT_RD,
    S_OUT_MUL,
    S_OUT_FIN
  } state_t;

  // per-lane controls from the sequencer
  typedef struct packed {
    logic ref_we;   // write the corrected sample into the reference store
    logic is_ref;   // pad is a reference pad
    logic sub_en;   // subtract the scaled reference
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/pad_noise_subtraction.sv -----
// ---------------------------------------------------------------------------
// pad_noise_subtraction: baseline and common-mode noise removal for pads
// Eight lanes hold the pad and reference stores; a merge stage sums what
// the lanes find and a shared divider produces baseline and amplitude.
// ---------------------------------------------------------------------------
//  channel  | handshake                | payload
//  config   | cfg_we                   | cfg_index, cfg_data
//  input    | in_valid / in_ready      | op, sample_0 .. sample_7
//  output   | out_valid / out_ready    | out_0 .. out_7, last, baseline,
//           |                          | amplitude, status
//
//  A request is written into the lane stores when it is taken; in skip mode
//  every request also yields its result at once through the output register.
//  Otherwise the last request of a pad starts a baseline pass and divide and,
//  for a pad with a stored reference, a sum pass and the amplitude divide;
//  each output request passes the store read, the registered multiply and
//  a load that waits for a free output register. No input is taken meanwhile.
//  Reset clears control, the chunk position and the reference flag.
// ---------------------------------------------------------------------------
`default_nettype none

module pad_noise_subtraction import pns_pkg::*; #(
  parameter int SAMPLES = 512
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    op,
  input  wire logic [RAW_W-1:0]        sample_0,
  input  wire logic [RAW_W-1:0]        sample_1,
  input  wire logic [RAW_W-1:0]        sample_2,
  input  wire logic [RAW_W-1:0]        sample_3,
  input  wire logic [RAW_W-1:0]        sample_4,
  input  wire logic [RAW_W-1:0]        sample_5,
  input  wire logic [RAW_W-1:0]        sample_6,
  input  wire logic [RAW_W-1:0]        sample_7,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      out_0,
  output logic signed [OUT_W-1:0]      out_1,
  output logic signed [OUT_W-1:0]      out_2,
  output logic signed [OUT_W-1:0]      out_3,
  output logic signed [OUT_W-1:0]      out_4,
  output logic signed [OUT_W-1:0]      out_5,
  output logic signed [OUT_W-1:0]      out_6,
  output logic signed [OUT_W-1:0]      out_7,
  output logic                         last,
  output logic [BL_W-1:0]              baseline,
  output logic signed [AMP_W-1:0]      amplitude,
  output logic [ST_W-1:0]              status
);

  localparam int CHUNKS  = SAMPLES / LANES;
  localparam int CHUNK_W = $clog2(CHUNKS);
  localparam int IDX_W   = $clog2(SAMPLES + 1);
  localparam int BND_W   = (IDX_W > WE_W) ? IDX_W : WE_W;
  localparam int SUM_W   = RAW_W + IDX_W;
  localparam int CSUM_W  = RAW_W + $clog2(LANES);
  localparam int ACC_W   = PRD_W + IDX_W;
  localparam int DVD_W   = ACC_W + AMP_FRAC;
  localparam int DVS_W   = ACC_W;

  // configuration registers
  logic             skip_sub;
  logic [WS_W-1:0]  win_start;
  logic [WE_W-1:0]  win_end;

  // control state
  state_t           state, state_next;
  logic [CHUNK_W-1:0] chunk_count;
  logic             ref_valid;
  logic             proc_op;
  logic [CHUNK_W-1:0] rd_k;
  logic [CHUNK_W-1:0] p1_k;
  logic             iss_act, p1_v, p2_v, p3_v;

  // results of the pad passes
  logic [BL_W-1:0]         bl;
  logic signed [AMP_W-1:0] amp;
  logic [ST_W-1:0]         pst;
  logic [SUM_W-1:0]        bl_sum;
  logic signed [ACC_W-1:0] acc_s1, acc_s2;
  logic signed [ACC_W-1:0] part_s1 [2];
  logic signed [ACC_W-1:0] part_s2 [2];

  // output register
  logic signed [OUT_W-1:0] out_q [LANES];

  // lane connections
  logic [RAW_W-1:0]        smp      [LANES];
  logic [RAW_W-1:0]        ln_raw   [LANES];
  logic signed [PRD_W-1:0] ln_rv    [LANES];
  logic signed [PRD_W-1:0] ln_rr    [LANES];
  logic signed [OUT_W-1:0] ln_corr  [LANES];
  lane_ctrl_t              lctrl;

  // window bounds
  logic [BND_W-1:0] win_lo, win_hi, win_end_x, win_n;
  logic             win_empty;

  // strobes
  logic in_fire, is_last_chunk, out_free, out_last, sweep_done;
  logic sweep_start, div_go_bl, div_go_amp, bl_set, zero_den_set, amp_set;
  logic out_load, out_enter;
  state_t post_bl;

  // merge and divider signals
  logic [CSUM_W-1:0]       chunk_sum;
  logic signed [ACC_W-1:0] half_s1 [2];
  logic signed [ACC_W-1:0] half_s2 [2];
  logic [ACC_W-1:0]        s1_abs;
  logic [DVD_W-1:0]        div_dvd, div_q;
  logic [DVS_W-1:0]        div_dvs;
  logic                    div_done, q_big;
  logic [AMP_W-1:0]        q_lo, amp_sat;

  assign smp[0] = sample_0;
  assign smp[1] = sample_1;
  assign smp[2] = sample_2;
  assign smp[3] = sample_3;
  assign smp[4] = sample_4;
  assign smp[5] = sample_5;
  assign smp[6] = sample_6;
  assign smp[7] = sample_7;

  // clip the window to the pad
  always_comb begin
    win_lo    = BND_W'(win_start);
    win_end_x = BND_W'(win_end);
    win_hi    = (win_end_x > BND_W'(SAMPLES)) ? BND_W'(SAMPLES) : win_end_x;
    win_empty = (win_hi <= win_lo);
    win_n     = win_hi - win_lo;
  end

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_sub  <= 1'b0;
      win_start <= '0;
      win_end   <= WEND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SKIP:   skip_sub  <= cfg_data[0];
        CFG_WSTART: win_start <= cfg_data[WS_W-1:0];
        CFG_WEND:   win_end   <= cfg_data[WE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid || out_ready;
  assign in_ready      = (state == S_IDLE) && out_free;
  assign in_fire       = in_valid && in_ready;
  assign is_last_chunk = (chunk_count == CHUNK_W'(CHUNKS - 1));
  assign out_last      = (rd_k == CHUNK_W'(CHUNKS - 1));
  assign sweep_done    = !iss_act && !p1_v && !p2_v && !p3_v;
  assign post_bl       = (proc_op == OP_PAD && ref_valid && !win_empty) ?
                         S_ST_SWEEP : S_OUT_RD;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && !skip_sub && is_last_chunk) state_next = S_BL_SWEEP;
      end
      S_BL_SWEEP: begin
        if (sweep_done) state_next = win_empty ? post_bl : S_BL_DIV;
      end
      S_BL_DIV: begin
        if (div_done) state_next = post_bl;
      end
      S_ST_SWEEP: begin
        if (sweep_done) state_next = (acc_s2 == '0) ? S_OUT_RD : S_AMP_DIV;
      end
      S_AMP_DIV: begin
        if (div_done) state_next = S_OUT_RD;
      end
      S_OUT_RD:  state_next = S_OUT_MUL;
      S_OUT_MUL: state_next = S_OUT_FIN;
      S_OUT_FIN: begin
        if (out_free) state_next = out_last ? S_IDLE : S_OUT_RD;
      end
    endcase
  end

  // sequencer strobes
  always_comb begin
    sweep_start  = (state != S_BL_SWEEP && state_next == S_BL_SWEEP) ||
                   (state != S_ST_SWEEP && state_next == S_ST_SWEEP);
    div_go_bl    = (state == S_BL_SWEEP) && sweep_done && !win_empty;
    div_go_amp   = (state == S_ST_SWEEP) && sweep_done && (acc_s2 != '0);
    bl_set       = ((state == S_BL_SWEEP) && sweep_done && win_empty) ||
                   ((state == S_BL_DIV) && div_done);
    zero_den_set = (state == S_ST_SWEEP) && sweep_done && (acc_s2 == '0);
    amp_set      = (state == S_AMP_DIV) && div_done;
    out_load     = (state == S_OUT_FIN) && out_free;
    out_enter    = (state_next == S_OUT_RD) && (state != S_OUT_FIN);
    lctrl.ref_we = out_load && (proc_op == OP_REF);
    lctrl.is_ref = (proc_op == OP_REF);
    lctrl.sub_en = (proc_op == OP_PAD) && (pst == ST_OK);
  end

  // hold state, chunk position, the reference flag and the pass and output valids
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chunk_count <= '0;
      ref_valid   <= 1'b0;
      iss_act     <= 1'b0;
      p1_v        <= 1'b0;
      p2_v        <= 1'b0;
      p3_v        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        chunk_count <= is_last_chunk ? '0 : chunk_count + 1'b1;
      end
      if (lctrl.ref_we && out_last) begin
        ref_valid <= 1'b1;
      end
      if (sweep_start) begin
        iss_act <= 1'b1;
      end else if (iss_act && out_last) begin
        iss_act <= 1'b0;
      end
      p1_v <= iss_act;
      p2_v <= p1_v;
      p3_v <= p2_v;
      if ((in_fire && skip_sub) || out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // advance the store address for sweeps and output requests; keep the request op
  always_ff @(posedge clk) begin
    if (sweep_start || out_enter) begin
      rd_k <= '0;
    end else if (iss_act || (out_load && !out_last)) begin
      rd_k <= rd_k + 1'b1;
    end
    p1_k <= rd_k;
    if (in_fire) begin
      proc_op <= op;
    end
  end

  // lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pns_lane #(
      .CHUNKS  (CHUNKS),
      .LANE_ID (l),
      .BND_W   (BND_W)
    ) u_lane (
      .clk     (clk),
      .wr_en   (in_fire),
      .wr_addr (chunk_count),
      .wr_data (smp[l]),
      .rd_addr (rd_k),
      .data_k  (p1_k),
      .ctrl    (lctrl),
      .win_lo  (win_lo),
      .win_hi  (win_hi),
      .bl      (bl),
      .amp     (amp),
      .win_raw (ln_raw[l]),
      .prod_rv (ln_rv[l]),
      .prod_rr (ln_rr[l]),
      .corr    (ln_corr[l])
    );
  end

  // merge lane results
  always_comb begin
    chunk_sum = '0;
    for (int l = 0; l < LANES; l++) begin
      chunk_sum = chunk_sum + CSUM_W'(ln_raw[l]);
    end
    for (int h = 0; h < 2; h++) begin
      half_s1[h] = '0;
      half_s2[h] = '0;
      for (int l = 0; l < LANES / 2; l++) begin
        half_s1[h] = half_s1[h] + ACC_W'(ln_rv[h * (LANES / 2) + l]);
        half_s2[h] = half_s2[h] + ACC_W'(ln_rr[h * (LANES / 2) + l]);
      end
    end
  end

  // accumulate window sums
  always_ff @(posedge clk) begin
    part_s1 <= half_s1;
    part_s2 <= half_s2;
    if (sweep_start) begin
      bl_sum <= '0;
      acc_s1 <= '0;
      acc_s2 <= '0;
    end else begin
      if (state == S_BL_SWEEP && p1_v) begin
        bl_sum <= bl_sum + SUM_W'(chunk_sum);
      end
      if (state == S_ST_SWEEP && p3_v) begin
        acc_s1 <= acc_s1 + part_s1[0] + part_s1[1];
        acc_s2 <= acc_s2 + part_s2[0] + part_s2[1];
      end
    end
  end

  // shared divider operands
  always_comb begin
    s1_abs  = acc_s1[ACC_W-1] ? ACC_W'(-acc_s1) : ACC_W'(acc_s1);
    div_dvd = div_go_amp ? {s1_abs, {AMP_FRAC{1'b0}}} : DVD_W'({bl_sum, 4'b0000});
    div_dvs = div_go_amp ? DVS_W'(acc_s2) : DVS_W'(win_n);
    q_big   = |div_q[DVD_W-1:AMP_W-1];
    q_lo    = div_q[AMP_W-1:0];
    if (acc_s1[ACC_W-1]) begin
      amp_sat = q_big ? 16'h8000 : AMP_W'(-q_lo);
    end else begin
      amp_sat = q_big ? 16'h7FFF : q_lo;
    end
  end

  pns_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go_bl || div_go_amp),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // hold baseline, amplitude and status of the pad
  always_ff @(posedge clk) begin
    if (bl_set) begin
      bl <= win_empty ? '0 : div_q[BL_W-1:0];
      if (proc_op == OP_REF) begin
        amp <= AMP_UNITY;
        pst <= ST_OK;
      end else begin
        amp <= '0;
        if (!ref_valid) begin
          pst <= ST_NO_REF;
        end else if (win_empty) begin
          pst <= ST_ZERO_DEN;
        end else begin
          pst <= ST_OK;
        end
      end
    end else if (zero_den_set) begin
      amp <= '0;
      pst <= ST_ZERO_DEN;
    end else if (amp_set) begin
      amp <= amp_sat;
      pst <= ST_OK;
    end
  end

  // load the output register
  always_ff @(posedge clk) begin
    if (in_fire && skip_sub) begin
      for (int l = 0; l < LANES; l++) begin
        out_q[l] <= {2'b00, smp[l], 4'b0000};
      end
      last      <= is_last_chunk;
      baseline  <= '0;
      amplitude <= '0;
      status    <= ST_OK;
    end else if (out_load) begin
      out_q     <= ln_corr;
      last      <= out_last;
      baseline  <= bl;
      amplitude <= amp;
      status    <= pst;
    end
  end

  assign out_0 = out_q[0];
  assign out_1 = out_q[1];
  assign out_2 = out_q[2];
  assign out_3 = out_q[3];
  assign out_4 = out_q[4];
  assign out_5 = out_q[5];
  assign out_6 = out_q[6];
  assign out_7 = out_q[7];

endmodule

`default_nettype wire

// ----- rtl/pns_div.sv -----
// ---------------------------------------------------------------------------
// pns_div: restoring unsigned divider
// One quotient bit per cycle; shared by the baseline and amplitude steps.
// ---------------------------------------------------------------------------
`default_nettype none

module pns_div import pns_pkg::*; #(
  parameter int DVD_W = 57,
  parameter int DVS_W = 45
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quotient[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = ~diff[DVS_W];
  end

  // control: count the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift in one quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pns_lane.sv -----
// ---------------------------------------------------------------------------
// pns_lane: one sample lane
// Holds the lane's share of the pad and reference stores and does the
// per-sample window test, least-squares products and final correction.
// ---------------------------------------------------------------------------
`default_nettype none

module pns_lane import pns_pkg::*; #(
  parameter int CHUNKS  = 64,
  parameter int LANE_ID = 0,
  parameter int BND_W   = 10,
  parameter int CHUNK_W = $clog2(CHUNKS)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [CHUNK_W-1:0]      wr_addr,
  input  wire logic [RAW_W-1:0]        wr_data,
  input  wire logic [CHUNK_W-1:0]      rd_addr,
  input  wire logic [CHUNK_W-1:0]      data_k,
  input  wire lane_ctrl_t              ctrl,
  input  wire logic [BND_W-1:0]        win_lo,
  input  wire logic [BND_W-1:0]        win_hi,
  input  wire logic [BL_W-1:0]         bl,
  input  wire logic signed [AMP_W-1:0] amp,
  output logic [RAW_W-1:0]             win_raw,
  output logic signed [PRD_W-1:0]      prod_rv,
  output logic signed [PRD_W-1:0]      prod_rr,
  output logic signed [OUT_W-1:0]      corr
);

  localparam int PA_W  = REF_W + AMP_W;
  localparam int RND_W = PA_W - AMP_FRAC;
  localparam int D_W   = RND_W + 2;

  logic [RAW_W-1:0]        pad_mem [CHUNKS];
  logic signed [REF_W-1:0] ref_mem [CHUNKS];
  logic [RAW_W-1:0]        raw;
  logic signed [REF_W-1:0] ref_q;
  logic signed [PA_W-1:0]  pa;

  logic [BND_W-1:0]        idx;
  logic                    in_win;
  logic signed [18:0]      v;
  logic signed [17:0]      v18;
  logic signed [18:0]      hi;
  logic signed [PA_W-1:0]  pa_bias;
  logic signed [RND_W-1:0] rnd;
  logic signed [D_W-1:0]   d;
  logic signed [OUT_W-1:0] d_sat;
  logic signed [18:0]      c;

  // pad store: written per request, read registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pad_mem[wr_addr] <= wr_data;
    end
    raw <= pad_mem[rd_addr];
  end

  // reference store: written during the output pass of a reference pad
  always_ff @(posedge clk) begin
    if (ctrl.ref_we) begin
      ref_mem[rd_addr] <= corr;
    end
    ref_q <= ref_mem[rd_addr];
  end

  // window test and baseline-corrected sample
  always_comb begin
    idx     = BND_W'(data_k) * BND_W'(LANES) + BND_W'(LANE_ID);
    in_win  = (idx >= win_lo) && (idx < win_hi);
    win_raw = in_win ? raw : '0;
    v       = $signed({3'b000, raw, 4'b0000}) - $signed({3'b000, bl});
    v18     = v[17:0];
    hi      = $signed(19'(ADC_MAX * 16)) - $signed({3'b000, bl});
  end

  // register products for the sums and the correction term
  always_ff @(posedge clk) begin
    if (in_win && (v != 19'sd0)) begin
      prod_rv <= ref_q * v18;
      prod_rr <= ref_q * ref_q;
    end else begin
      prod_rv <= '0;
      prod_rr <= '0;
    end
    pa <= ref_q * amp;
  end

  // round the correction half up, subtract, saturate and clamp
  always_comb begin
    pa_bias = pa + PA_W'(2048);
    rnd     = RND_W'(pa_bias >>> AMP_FRAC);
    d       = {{(D_W-19){v[18]}}, v} - {{2{rnd[RND_W-1]}}, rnd};
    if (d > D_W'(131071)) begin
      d_sat = 18'sh1FFFF;
    end else if (d < -D_W'(131072)) begin
      d_sat = 18'sh20000;
    end else begin
      d_sat = d[OUT_W-1:0];
    end
    c = ctrl.sub_en ? {d_sat[17], d_sat} : v;
    if (raw == '0) begin
      c = '0;
    end else if (raw == RAW_W'(ADC_MAX)) begin
      c = hi;
    end
    if (c > hi) begin
      c = hi;
    end
    corr = ctrl.is_ref ? v18 : c[OUT_W-1:0];
  end

endmodule

`default_nettype wire
